/* rtl/tpa_pkg.sv */
// ============================================================================
// tpa_pkg
// Types and fixed widths shared by the triangle perimeter and area unit.
// ============================================================================
`default_nettype none

package tpa_pkg;

    // Coordinate width, signed Q8.8.
    localparam int COORD_BITS = 16;
    // Coordinate difference, one bit wider than a coordinate.
    localparam int DIFF_W     = COORD_BITS + 1;
    // Square of a difference magnitude.
    localparam int SQ_W       = 2 * DIFF_W;
    // Sum of three squares, Q20.16.
    localparam int SUM_W      = SQ_W + 2;
    // Side length, Q10.8.
    localparam int LEN_W      = SUM_W / 2;
    // Full perimeter s = d1 + d2 + d3.
    localparam int S_W        = LEN_W + 2;
    // Heron product s * (s - 2 d1) * (s - 2 d2) * (s - 2 d3).
    localparam int PROD_W     = 4 * S_W;
    // Heron product divided by sixteen.
    localparam int Q_W        = PROD_W - 4;
    // Root of that quotient, before clamping.
    localparam int AREA_RT_W  = (Q_W + 1) / 2;

    localparam int PERIM_W    = 20;
    localparam int AREA_W     = 34;

    localparam logic [PERIM_W-1:0] PERIM_MAX = '1;
    localparam logic [AREA_W-1:0]  AREA_MAX  = '1;

    // Cycles from an accepted start to its result strobe.
    localparam int LATENCY = 2 + LEN_W + 4 + AREA_RT_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic signed [COORD_BITS-1:0] a_z;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic signed [COORD_BITS-1:0] b_z;
        logic signed [COORD_BITS-1:0] c_x;
        logic signed [COORD_BITS-1:0] c_y;
        logic signed [COORD_BITS-1:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter;
        logic [AREA_W-1:0]  area;
    } t_tri_out;

endpackage

`default_nettype wire

/* rtl/triangle_perimeter_area_3d_unit.sv */
// ============================================================================
// triangle_perimeter_area_3d_unit
// Perimeter and Heron area of a 3D triangle in fixed point.
// ============================================================================
//
//  channel   ports                        transfer when
//  -------   --------------------------   ---------------------------
//  command   i_start, i_tri, o_busy       i_start high and o_busy low
//  result    o_done, o_res                o_done high (one cycle only)
//
// One triangle can be taken every clock cycle; o_busy is always low.
// Each result follows its command transfer through two lane register stages,
// 18 side-length root stages (one bit per stage), four Heron product stages
// and 38 area root stages; tpa_pkg::LATENCY holds the total.
// The synchronous active-low reset clears every valid bit in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module triangle_perimeter_area_3d_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  tpa_pkg::t_tri_in       i_tri,
    output logic                   o_busy,
    output logic                   o_done,
    output tpa_pkg::t_tri_out      o_res
);

    logic signed [tpa_pkg::COORD_BITS-1:0] pt_a [3];
    logic signed [tpa_pkg::COORD_BITS-1:0] pt_b [3];
    logic signed [tpa_pkg::COORD_BITS-1:0] pt_c [3];

    logic                      acc;
    logic                      vld1, vld2, vld3;
    logic [tpa_pkg::LEN_W-1:0] d1, d2, d3;

    // The pipeline never blocks, so a command is taken whenever it is offered.
    assign o_busy = 1'b0;
    assign acc    = i_start & ~o_busy;

    assign pt_a[0] = i_tri.a_x;
    assign pt_a[1] = i_tri.a_y;
    assign pt_a[2] = i_tri.a_z;
    assign pt_b[0] = i_tri.b_x;
    assign pt_b[1] = i_tri.b_y;
    assign pt_b[2] = i_tri.b_z;
    assign pt_c[0] = i_tri.c_x;
    assign pt_c[1] = i_tri.c_y;
    assign pt_c[2] = i_tri.c_z;

    // Three identical lanes work out |A-B|, |B-C| and |A-C| side by side.
    tpa_side_lane u_lane_ab (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (acc),
        .i_p (pt_a), .i_q (pt_b), .o_vld (vld1), .o_len (d1)
    );

    tpa_side_lane u_lane_bc (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (acc),
        .i_p (pt_b), .i_q (pt_c), .o_vld (vld2), .o_len (d2)
    );

    tpa_side_lane u_lane_ac (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (acc),
        .i_p (pt_a), .i_q (pt_c), .o_vld (vld3), .o_len (d3)
    );

    // The lanes have equal latency, so their valid bits always agree.
    tpa_heron u_heron (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld1 & vld2 & vld3),
        .i_d1    (d1),
        .i_d2    (d2),
        .i_d3    (d3),
        .o_vld   (o_done),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* rtl/tpa_isqrt.sv */
// ============================================================================
// tpa_isqrt
// Pipelined integer square root, truncated, one result bit per stage.
// ============================================================================
`default_nettype none

module tpa_isqrt #(
    parameter int IN_W  = 36,
    parameter int OUT_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire logic [IN_W-1:0]  i_val,
    output logic                  o_vld,
    output logic [OUT_W-1:0]      o_root
);

    localparam int NW = 2 * OUT_W;

    logic [NW-1:0] w_num [0:OUT_W];
    logic [NW-1:0] w_res [0:OUT_W];
    logic          w_vld [0:OUT_W];

    assign w_num[0] = NW'(i_val);
    assign w_res[0] = '0;
    assign w_vld[0] = i_vld;

    // Classic digit-by-digit method: each stage tries one root bit.
    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam logic [NW-1:0] BIT_K = NW'(1) << (NW - 2 - 2 * k);
        logic [NW-1:0] trial;
        logic [NW-1:0] r_num;
        logic [NW-1:0] r_res;
        logic          r_vld;

        always_comb begin
            trial = w_res[k] + BIT_K;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld[k];
            end
            if (w_num[k] >= trial) begin
                r_num <= w_num[k] - trial;
                r_res <= (w_res[k] >> 1) + BIT_K;
            end else begin
                r_num <= w_num[k];
                r_res <= w_res[k] >> 1;
            end
        end

        assign w_num[k+1] = r_num;
        assign w_res[k+1] = r_res;
        assign w_vld[k+1] = r_vld;
    end

    assign o_vld  = w_vld[OUT_W];
    assign o_root = w_res[OUT_W][OUT_W-1:0];

    // Remainder of the last stage is not needed.
    logic unused_num;
    assign unused_num = ^w_num[OUT_W];

endmodule

`default_nettype wire

/* rtl/tpa_side_lane.sv */
// ============================================================================
// tpa_side_lane
// One side-length lane: differences, squares, sum and square root.
// ============================================================================
`default_nettype none

module tpa_side_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_vld,
    input  wire logic signed [tpa_pkg::COORD_BITS-1:0] i_p [3],
    input  wire logic signed [tpa_pkg::COORD_BITS-1:0] i_q [3],
    output logic                                       o_vld,
    output logic [tpa_pkg::LEN_W-1:0]                  o_len
);

    localparam int CB = tpa_pkg::COORD_BITS;
    localparam int DW = tpa_pkg::DIFF_W;
    localparam int QW = tpa_pkg::SQ_W;
    localparam int SW = tpa_pkg::SUM_W;

    logic [DW-1:0] mag [3];
    logic [QW-1:0] r_sq [3];
    logic          r_vld1;
    logic [SW-1:0] r_sum;
    logic          r_vld2;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic signed [DW-1:0] diff;
        always_comb begin
            diff   = $signed({i_p[i][CB-1], i_p[i]}) - $signed({i_q[i][CB-1], i_q[i]});
            mag[i] = diff[DW-1] ? DW'(-diff) : DW'(diff);
        end
        always_ff @(posedge i_clk) begin
            r_sq[i] <= QW'(mag[i] * mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
        r_sum <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
    end

    tpa_isqrt #(
        .IN_W  (SW),
        .OUT_W (tpa_pkg::LEN_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld2),
        .i_val   (r_sum),
        .o_vld   (o_vld),
        .o_root  (o_len)
    );

endmodule

`default_nettype wire

/* rtl/tpa_heron.sv */
// ============================================================================
// tpa_heron
// Merge stage: perimeter, Heron product and area root.
// ============================================================================
`default_nettype none

module tpa_heron (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [tpa_pkg::LEN_W-1:0]     i_d1,
    input  wire logic [tpa_pkg::LEN_W-1:0]     i_d2,
    input  wire logic [tpa_pkg::LEN_W-1:0]     i_d3,
    output logic                               o_vld,
    output tpa_pkg::t_tri_out                  o_res
);

    localparam int SW = tpa_pkg::S_W;
    localparam int PW = tpa_pkg::PROD_W;
    localparam int RW = tpa_pkg::AREA_RT_W;
    localparam int AW = tpa_pkg::AREA_W;

    logic [SW:0]     f1, f2, f3;
    logic [SW-1:0]   s_sum;

    logic            r_vld1, r_vld2, r_vld3, r_vld4;
    logic [SW-1:0]   r_s1, r_s2, r_s3, r_s4;
    logic [SW-1:0]   r_f1, r_f2, r_f3;
    logic            r_neg1, r_neg2, r_neg3;
    logic [2*SW-1:0] r_x, r_y;
    logic [3*SW-1:0] r_pl, r_ph;
    logic [PW-1:0]   r_p;

    logic            rt_vld;
    logic [RW-1:0]   rt_root;
    logic [SW-1:0]   r_sdly [RW];

    always_comb begin
        s_sum = SW'(i_d1) + SW'(i_d2) + SW'(i_d3);
        f1    = {1'b0, s_sum} - (SW+1)'({i_d1, 1'b0});
        f2    = {1'b0, s_sum} - (SW+1)'({i_d2, 1'b0});
        f3    = {1'b0, s_sum} - (SW+1)'({i_d3, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
        r_s1   <= s_sum;
        r_f1   <= f1[SW-1:0];
        r_f2   <= f2[SW-1:0];
        r_f3   <= f3[SW-1:0];
        r_neg1 <= f1[SW] | f2[SW] | f3[SW];

        r_s2   <= r_s1;
        r_neg2 <= r_neg1;
        r_x    <= r_s1 * r_f1;
        r_y    <= r_f2 * r_f3;

        r_s3   <= r_s2;
        r_neg3 <= r_neg2;
        r_pl   <= r_x * r_y[SW-1:0];
        r_ph   <= r_x * r_y[2*SW-1:SW];

        // A negative factor means a degenerate triangle: the area is zero.
        r_s4   <= r_s3;
        r_p    <= r_neg3 ? '0 : PW'(r_pl) + (PW'(r_ph) << SW);
    end

    tpa_isqrt #(
        .IN_W  (tpa_pkg::Q_W),
        .OUT_W (RW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld4),
        .i_val   (r_p[PW-1:4]),
        .o_vld   (rt_vld),
        .o_root  (rt_root)
    );

    // The perimeter waits alongside the area root.
    always_ff @(posedge i_clk) begin
        r_sdly[0] <= r_s4;
        for (int k = 1; k < RW; k++) begin
            r_sdly[k] <= r_sdly[k-1];
        end
    end

    always_comb begin
        o_vld = rt_vld;
        if (SW > tpa_pkg::PERIM_W && r_sdly[RW-1] > SW'(tpa_pkg::PERIM_MAX)) begin
            o_res.perimeter = tpa_pkg::PERIM_MAX;
        end else begin
            o_res.perimeter = tpa_pkg::PERIM_W'(r_sdly[RW-1]);
        end
        if (rt_root > RW'(tpa_pkg::AREA_MAX)) begin
            o_res.area = tpa_pkg::AREA_MAX;
        end else begin
            o_res.area = rt_root[AW-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/tpa_checker.sv */
// ============================================================================
// tpa_checker
// Port-level checks for the triangle perimeter and area unit.
// ============================================================================
`default_nettype none

module tpa_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              o_busy,
    input  wire logic              o_done,
    input  tpa_pkg::t_tri_out      o_res
);

    logic [2*tpa_pkg::PERIM_W-1:0] perim_sq;
    assign perim_sq = (2*tpa_pkg::PERIM_W)'(o_res.perimeter) *
                      (2*tpa_pkg::PERIM_W)'(o_res.perimeter);

    // The unit never refuses a command.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy asserted");

    // Every result comes from a command a fixed number of cycles earlier.
    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, tpa_pkg::LATENCY))
        else $error("result without a matching command");

    // A triangle with zero perimeter has zero area.
    a_zero_perim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.perimeter == '0) |-> o_res.area == '0)
        else $error("nonzero area with zero perimeter");

    // The area never exceeds the isoperimetric bound, here loosened to s^2/16.
    a_area_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (2*tpa_pkg::PERIM_W)'(o_res.area) <= (perim_sq >> 4))
        else $error("area larger than the perimeter allows");

endmodule

bind triangle_perimeter_area_3d_unit tpa_checker u_tpa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

`default_nettype wire
